>>> rtl/core/mfp_pkg.sv
// ----------------------------------------------------------------------------
// mfp_pkg
// Shared types, codes and constants of the MIDI file event parser.
// ----------------------------------------------------------------------------
package mfp_pkg;

  localparam int TICK_BITS_DEFAULT = 32;
  localparam int NOTE_ADDR_W       = 11;   // 16 channels x 128 pitches
  localparam int NOTE_DEPTH        = 1 << NOTE_ADDR_W;
  localparam int TRACK_W           = 16;

  localparam logic [7:0] META_TEMPO = 8'h51;

  typedef enum logic [3:0] {
    KIND_CHANNEL   = 4'd0,
    KIND_NOTE      = 4'd1,
    KIND_UNMATCHED = 4'd2,
    KIND_TEMPO     = 4'd3,
    KIND_META_HEAD = 4'd4,
    KIND_META_BYTE = 4'd5,
    KIND_SKIPPED   = 4'd6,
    KIND_HEADER    = 4'd7,
    KIND_ERROR     = 4'd8
  } kind_t;

  typedef struct packed {
    kind_t        kind;
    logic [15:0]  track_index;
    logic [31:0]  tick;
    logic [7:0]   status_or_type;
    logic [7:0]   first_data;
    logic [7:0]   second_data;
    logic [31:0]  value;
    logic [31:0]  note_start;
    logic         end_of_track;
    logic         end_of_file;
  } res_t;

  typedef struct packed {
    logic                   rd;
    logic                   wr;
    logic [NOTE_ADDR_W-1:0] addr;
  } note_req_t;

  // "MThd" followed by the header length 0,0,0,6
  function automatic logic [7:0] file_sig(input logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0:    r = 8'h4D;
      3'd1:    r = 8'h54;
      3'd2:    r = 8'h68;
      3'd3:    r = 8'h64;
      3'd7:    r = 8'h06;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // "MTrk"
  function automatic logic [7:0] track_sig(input logic [1:0] i);
    logic [7:0] r;
    case (i)
      2'd0:    r = 8'h4D;
      2'd1:    r = 8'h54;
      2'd2:    r = 8'h72;
      default: r = 8'h6B;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/mfp_note_mem.sv
// ----------------------------------------------------------------------------
// mfp_note_mem
// Open-note table: one synchronous RAM, registered read, cleared after reset.
// ----------------------------------------------------------------------------
module mfp_note_mem
  import mfp_pkg::*;
#(
  parameter int TICK_BITS = TICK_BITS_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  note_req_t               req,
  input  logic [TICK_BITS+16:0]   wdata,
  output logic [TICK_BITS+16:0]   rdata,
  output logic                    busy
);

  logic [TICK_BITS+16:0]  mem [NOTE_DEPTH];
  logic [NOTE_ADDR_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == NOTE_ADDR_W'(NOTE_DEPTH - 1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (req.wr) begin
      mem[req.addr] <= wdata;
    end
    if (req.rd) rdata <= mem[req.addr];
  end

endmodule

>>> rtl/core/mfp_out_skid.sv
// ----------------------------------------------------------------------------
// mfp_out_skid
// Output register with a skid stage, so input is taken while a result waits.
// ----------------------------------------------------------------------------
module mfp_out_skid
  import mfp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  res_t in_res,
  output logic in_ready,
  output logic out_valid,
  output res_t out_res,
  input  logic out_ready
);

  logic skid_valid;
  res_t skid_res;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_res    <= skid_res;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_res   <= in_res;
        out_valid <= in_valid;
      end
    end else if (in_valid) begin
      skid_res   <= in_res;
      skid_valid <= 1'b1;
    end
  end

endmodule

>>> rtl/core/mfp_parser.sv
// ----------------------------------------------------------------------------
// mfp_parser
// Byte-level chunk and event parser; pairs note-offs through the note table.
// ----------------------------------------------------------------------------
module mfp_parser
  import mfp_pkg::*;
#(
  parameter int TICK_BITS = TICK_BITS_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    accept,
  input  logic [7:0]              data_byte,
  output note_req_t               mem_req,
  output logic [TICK_BITS+16:0]   mem_wdata,
  input  logic [TICK_BITS+16:0]   mem_rdata,
  output logic                    res_valid,
  output res_t                    res
);

  typedef enum logic [3:0] {
    PH_FILE_HEAD, PH_TRACK_HEAD, PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2,
    PH_META_TYPE, PH_META_LEN, PH_META_DATA, PH_SKIP, PH_DONE, PH_ERROR
  } phase_t;

  phase_t                phase, phase_next;
  logic [3:0]            cnt, cnt_next;
  logic [31:0]           chunk_left, chunk_left_next;
  logic [TICK_BITS-1:0]  cur_tick, cur_tick_next;
  logic [TICK_BITS-1:0]  dacc, dacc_next;
  logic [23:0]           tacc, tacc_next;
  logic [7:0]            held_status, held_status_next;
  logic [7:0]            held_data, held_data_next;
  logic [31:0]           meta_left, meta_left_next;
  logic [15:0]           tracks_left, tracks_left_next;
  logic [15:0]           track_cnt, track_cnt_next;
  logic [15:0]           tpq, tpq_next;

  logic [7:0]            b;
  logic [3:0]            hi;
  logic [31:0]           chunk_dec, chunk_shift, meta_shift, meta_dec;
  logic [TICK_BITS-1:0]  dacc_shift, st_tick, note_len;
  logic [23:0]           tacc_shift;
  logic [15:0]           tracks_dec;
  logic                  body, emit, complete, err;
  logic                  ent_valid;
  logic [15:0]           ent_tag;

  assign b           = data_byte;
  assign hi          = held_status[7:4];
  assign chunk_dec   = chunk_left - 32'd1;
  assign chunk_shift = {chunk_left[23:0], b};
  assign meta_shift  = {meta_left[24:0], b[6:0]};
  assign meta_dec    = meta_left - 32'd1;
  assign dacc_shift  = {dacc[TICK_BITS-8:0], b[6:0]};
  assign tacc_shift  = {tacc[15:0], b};
  assign tracks_dec  = tracks_left - 16'd1;
  assign ent_valid   = mem_rdata[TICK_BITS+16];
  assign ent_tag     = mem_rdata[TICK_BITS+15:TICK_BITS];
  assign st_tick     = mem_rdata[TICK_BITS-1:0];
  assign note_len    = cur_tick - st_tick;
  assign mem_wdata   = {1'b1, track_cnt, cur_tick};

  always_comb begin
    phase_next       = phase;
    cnt_next         = cnt;
    chunk_left_next  = chunk_left;
    cur_tick_next    = cur_tick;
    dacc_next        = dacc;
    tacc_next        = tacc;
    held_status_next = held_status;
    held_data_next   = held_data;
    meta_left_next   = meta_left;
    tracks_left_next = tracks_left;
    track_cnt_next   = track_cnt;
    tpq_next         = tpq;
    body             = 1'b0;
    emit             = 1'b0;
    complete         = 1'b0;
    err              = 1'b0;
    mem_req          = '0;
    res              = '0;
    res.track_index  = track_cnt;
    res.tick         = 32'(cur_tick);

    if (accept) begin
      case (phase)
        PH_FILE_HEAD: begin
          if (cnt < 4'd8 && b != file_sig(cnt[2:0])) begin
            err = 1'b1;
          end else begin
            cnt_next = cnt + 4'd1;
            if (cnt == 4'd9)  held_status_next = b;
            if (cnt == 4'd10) tracks_left_next = {b, 8'h00};
            if (cnt == 4'd11) tracks_left_next = {tracks_left[15:8], b};
            if (cnt == 4'd12) tpq_next = {b, 8'h00};
            if (cnt == 4'd13) begin
              emit               = 1'b1;
              cnt_next           = '0;
              res.kind           = KIND_HEADER;
              res.tick           = '0;
              res.status_or_type = held_status;
              res.value          = {16'h0, tpq[15:8], b};
              res.note_start     = {16'h0, tracks_left};
              if (tracks_left == 16'd0) begin
                res.end_of_file = 1'b1;
                phase_next      = PH_DONE;
              end else begin
                phase_next = PH_TRACK_HEAD;
              end
              tpq_next = {tpq[15:8], b};
            end
          end
        end
        PH_TRACK_HEAD: begin
          if (cnt < 4'd4 && b != track_sig(cnt[1:0])) begin
            err = 1'b1;
          end else begin
            cnt_next = cnt + 4'd1;
            if (cnt >= 4'd4) chunk_left_next = chunk_shift;
            if (cnt == 4'd7) begin
              cnt_next      = '0;
              cur_tick_next = '0;
              dacc_next     = '0;
              phase_next    = PH_DELTA;
              if (chunk_shift == 32'd0) begin
                // empty track: closes at once
                emit     = 1'b1;
                complete = 1'b1;
                res.kind = KIND_SKIPPED;
                res.tick = '0;
              end
            end
          end
        end
        PH_DELTA: begin
          body      = 1'b1;
          dacc_next = dacc_shift;
          if (!b[7]) begin
            cur_tick_next = cur_tick + dacc_shift;
            dacc_next     = '0;
            phase_next    = PH_STATUS;
          end
        end
        PH_STATUS: begin
          body             = 1'b1;
          held_status_next = b;
          if (b[7:4] == 4'hF)  phase_next = PH_META_TYPE;
          else if (b[7])       phase_next = PH_DATA1;
          else                 phase_next = PH_SKIP;
        end
        PH_DATA1: begin
          body = 1'b1;
          if (hi == 4'hC || hi == 4'hD) begin
            emit               = 1'b1;
            complete           = 1'b1;
            res.kind           = KIND_CHANNEL;
            res.status_or_type = held_status;
            res.first_data     = b;
          end else begin
            held_data_next = b;
            phase_next     = PH_DATA2;
            // fetch the open note now; the entry is ready for the next byte
            mem_req.rd     = 1'b1;
            mem_req.addr   = {held_status[3:0], b[6:0]};
          end
        end
        PH_DATA2: begin
          body               = 1'b1;
          emit               = 1'b1;
          complete           = 1'b1;
          res.status_or_type = held_status;
          res.first_data     = held_data;
          res.second_data    = b;
          mem_req.addr       = {held_status[3:0], held_data[6:0]};
          if (hi == 4'h8) begin
            if (ent_valid && ent_tag == track_cnt) begin
              res.kind       = KIND_NOTE;
              res.value      = 32'(note_len);
              res.note_start = 32'(st_tick);
            end else begin
              res.kind = KIND_UNMATCHED;
            end
          end else begin
            res.kind   = KIND_CHANNEL;
            mem_req.wr = (hi == 4'h9);
          end
        end
        PH_META_TYPE: begin
          body           = 1'b1;
          held_data_next = b;
          meta_left_next = '0;
          phase_next     = PH_META_LEN;
        end
        PH_META_LEN: begin
          body           = 1'b1;
          meta_left_next = meta_shift;
          if (!b[7]) begin
            tacc_next          = '0;
            res.status_or_type = held_data;
            if (held_data == META_TEMPO) begin
              if (meta_shift == 32'd0) begin
                emit     = 1'b1;
                complete = 1'b1;
                res.kind = KIND_TEMPO;
              end else begin
                phase_next = PH_META_DATA;
              end
            end else begin
              emit      = 1'b1;
              res.kind  = KIND_META_HEAD;
              res.value = meta_shift;
              if (meta_shift == 32'd0) complete = 1'b1;
              else                     phase_next = PH_META_DATA;
            end
          end
        end
        PH_META_DATA: begin
          body               = 1'b1;
          meta_left_next     = meta_dec;
          res.status_or_type = held_data;
          if (held_data == META_TEMPO) begin
            tacc_next = tacc_shift;
            if (meta_dec == 32'd0) begin
              emit      = 1'b1;
              complete  = 1'b1;
              res.kind  = KIND_TEMPO;
              res.value = {8'h00, tacc_shift};
              tacc_next = '0;
            end
          end else begin
            emit           = 1'b1;
            complete       = (meta_dec == 32'd0);
            res.kind       = KIND_META_BYTE;
            res.first_data = b;
            res.value      = meta_dec;
          end
        end
        PH_SKIP: begin
          body               = 1'b1;
          emit               = 1'b1;
          complete           = 1'b1;
          res.kind           = KIND_SKIPPED;
          res.status_or_type = held_status;
          res.first_data     = b;
        end
        default: ;
      endcase

      if (body) chunk_left_next = chunk_dec;
      if (body && !complete && chunk_dec == 32'd0) err = 1'b1;

      if (err) begin
        emit            = 1'b1;
        res             = '0;
        res.kind        = KIND_ERROR;
        res.track_index = track_cnt;
        phase_next      = PH_ERROR;
      end else if (complete) begin
        phase_next = PH_DELTA;
        if (chunk_left_next == 32'd0) begin
          res.end_of_track = 1'b1;
          track_cnt_next   = track_cnt + 16'd1;
          tracks_left_next = tracks_dec;
          if (tracks_dec == 16'd0) begin
            res.end_of_file = 1'b1;
            phase_next      = PH_DONE;
          end else begin
            phase_next = PH_TRACK_HEAD;
            cnt_next   = '0;
          end
        end
      end
    end
    res_valid = emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_FILE_HEAD;
      cnt         <= '0;
      chunk_left  <= '0;
      cur_tick    <= '0;
      dacc        <= '0;
      tacc        <= '0;
      held_status <= '0;
      held_data   <= '0;
      meta_left   <= '0;
      tracks_left <= '0;
      track_cnt   <= '0;
      tpq         <= '0;
    end else begin
      phase       <= phase_next;
      cnt         <= cnt_next;
      chunk_left  <= chunk_left_next;
      cur_tick    <= cur_tick_next;
      dacc        <= dacc_next;
      tacc        <= tacc_next;
      held_status <= held_status_next;
      held_data   <= held_data_next;
      meta_left   <= meta_left_next;
      tracks_left <= tracks_left_next;
      track_cnt   <= track_cnt_next;
      tpq         <= tpq_next;
    end
  end

endmodule

>>> rtl/core/midi_file_event_parser_core.sv
// ----------------------------------------------------------------------------
// midi_file_event_parser_core
// Standard MIDI file parser: file bytes in, timed events out.
// ----------------------------------------------------------------------------
// Input: one file byte per word on s_t*. Output: at most one event word per
// input byte on m_t*; tuser carries the kind and end of file, tlast end of
// track. The block takes one byte per cycle while s_tready is high. The byte
// that completes an event has its word registered at the output or in the skid
// stage. Note pairing reads the open-note RAM at the first data byte and writes
// it at the second of a note-on, one access per cycle on its single port.
// After reset the note RAM is cleared one entry per cycle, all 2048 entries;
// s_tready stays low until the clear is done. A header or signature mismatch,
// or a track chunk ending inside an event, gives one error word; further
// bytes are then consumed with no output until reset. After end of file bytes
// are consumed silently. When m_tready is low an output register plus a skid
// stage hold up to two words; past the clear, s_tready drops only on a full skid.
// ----------------------------------------------------------------------------
module midi_file_event_parser_core
  import mfp_pkg::*;
#(
  parameter int TICK_BITS = TICK_BITS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // data_byte
  output logic         m_tvalid,
  input  logic         m_tready,
  // track_index, tick, status_or_type, first_data, second_data, value,
  // note_start
  output logic [135:0] m_tdata,
  output logic         m_tlast,   // end_of_track
  output logic [4:0]   m_tuser    // kind, end_of_file
);

  note_req_t             mem_req;
  logic [TICK_BITS+16:0] mem_wdata, mem_rdata;
  logic                  mem_busy, skid_ready, accept, res_valid;
  res_t                  res, out_res;

  assign s_tready = skid_ready && !mem_busy;
  assign accept   = s_tvalid && s_tready;

  mfp_note_mem #(.TICK_BITS(TICK_BITS)) u_mem (
    .clk   (clk),
    .rst   (rst),
    .req   (mem_req),
    .wdata (mem_wdata),
    .rdata (mem_rdata),
    .busy  (mem_busy)
  );

  mfp_parser #(.TICK_BITS(TICK_BITS)) u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (s_tdata),
    .mem_req   (mem_req),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res       (res)
  );

  mfp_out_skid u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_res    (res),
    .in_ready  (skid_ready),
    .out_valid (m_tvalid),
    .out_res   (out_res),
    .out_ready (m_tready)
  );

  assign m_tdata = {out_res.note_start, out_res.value, out_res.second_data,
                    out_res.first_data, out_res.status_or_type, out_res.tick,
                    out_res.track_index};
  assign m_tlast = out_res.end_of_track;
  assign m_tuser = {out_res.end_of_file, out_res.kind};

endmodule

>>> rtl/core/mfp_checker.sv
// ----------------------------------------------------------------------------
// mfp_checker
// Port-level checks of the MIDI file parser, bound to the top level.
// ----------------------------------------------------------------------------
module mfp_checker
  import mfp_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [135:0] m_tdata,
  input logic         m_tlast,
  input logic [4:0]   m_tuser
);

  // note table clear holds off input right after reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input taken during note table clear");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled word changed");

  a_eof: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[4] |-> m_tlast || m_tuser[3:0] == KIND_HEADER)
    else $error("end of file without end of track");

  a_error_word: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[3:0] == KIND_ERROR |->
      m_tdata[135:16] == '0 && !m_tlast && !m_tuser[4])
    else $error("error word carries data");

endmodule

bind midi_file_event_parser_core mfp_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
